[src/gntd_pkg.sv]
// ----------------------------------------------------------------------------
// Glob name, type and depth filter package
// Shared types and constants of the path filter: character codes, file mode
// type codes, register indexes and the control bundle of the matcher cells.
// ----------------------------------------------------------------------------
package gntd_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned MODE_W   = 16;
	localparam int unsigned DEPTH_W  = 8;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned LEN_W    = 6;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

	localparam logic [MODE_W-1:0] MODE_TYPE_MASK = 16'o170000;
	localparam logic [MODE_W-1:0] MODE_DIR       = 16'o040000;
	localparam logic [MODE_W-1:0] MODE_REG       = 16'o100000;

	typedef enum logic [1:0] {
		TF_NONE = 2'd0,
		TF_REG  = 2'd1,
		TF_DIR  = 2'd2,
		TF_ANY  = 2'd3
	} type_filter_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TYPE_FILTER    = 3'd0,
		REG_MIN_DEPTH      = 3'd1,
		REG_NAME_FILTER_ON = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_PATTERN_W0     = 3'd4,
		REG_PATTERN_W1     = 3'd5,
		REG_PATTERN_W2     = 3'd6,
		REG_PATTERN_W3     = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic              load;
		logic              at_start;
		logic              restart;
		logic [CHAR_W-1:0] ch;
	} cell_ctrl_t;

endpackage

[src/gntd_if.sv]
// ----------------------------------------------------------------------------
// Path filter stream interfaces
// Valid/ready channels for path character beats and for filter result beats.
// ----------------------------------------------------------------------------
interface gntd_path_if;
	import gntd_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  ch;
	logic               last_char;
	logic [MODE_W-1:0]  file_mode;
	logic [DEPTH_W-1:0] depth;

	modport source (output valid, ch, last_char, file_mode, depth, input ready);
	modport sink (input valid, ch, last_char, file_mode, depth, output ready);
endinterface

interface gntd_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink (input valid, matched, output ready);
endinterface

[src/gntd_cell.sv]
// ----------------------------------------------------------------------------
// Glob matcher cell
// Holds the live bit of one pattern position, advances it on each character
// and passes match, star-closure and start-set bits to the next cell.
// ----------------------------------------------------------------------------
module gntd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gntd_pkg::cell_ctrl_t          ctrl,
	input  logic [gntd_pkg::CHAR_W-1:0]   pchar,
	input  logic                          en,
	input  logic                          start_in,
	input  logic                          match_in,
	input  logic                          close_in,
	output logic                          start_out,
	output logic                          match_out,
	output logic                          close_out,
	output logic                          closed
);
	import gntd_pkg::*;

	logic live_q;
	logic star;
	logic base;
	logic raw;

	assign star      = en && (pchar == CH_STAR);
	assign base      = ctrl.at_start ? start_in : live_q;
	assign start_out = start_in && star;
	assign match_out = base && en && !star && ((pchar == CH_QMARK) || (pchar == ctrl.ch));
	assign raw       = (base && star) || match_in;
	assign closed    = raw || close_in;
	assign close_out = closed && star;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctrl.load) begin
			live_q <= ctrl.restart ? start_in : closed;
		end
	end

endmodule

[src/glob_name_type_depth_filter.sv]
// ----------------------------------------------------------------------------
// Glob name, type and depth filter
// Streams path characters through a row of glob matcher cells and flags, on
// the last character, whether the path passes the depth, type and name tests.
// ----------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after the last character beat.
// Throughput: one character beat per cycle while the result side takes beats.
// The row of cells updates every pattern position in the same cycle.
// Reset clears all registers to their reset values at once; no clearing pass.
// ----------------------------------------------------------------------------
module glob_name_type_depth_filter #(
	parameter int unsigned PATTERN_MAX = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gntd_path_if.sink                        path,
	gntd_result_if.source                    result,
	input  logic                             cfg_wr_en,
	input  logic [gntd_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [gntd_pkg::WORD_W-1:0]      cfg_wdata
);
	import gntd_pkg::*;

	localparam int unsigned PL_W = $clog2(PATTERN_MAX + 1);

	type_filter_t       type_filter_q;
	logic [DEPTH_W-1:0] min_depth_q;
	logic               name_filter_on_q;
	logic [LEN_W-1:0]   pattern_length_q;
	logic [WORD_W-1:0]  pattern_words_q [NUM_WORDS];

	logic               at_start_q;
	logic               out_valid_q;
	logic               matched_q;

	logic               accept;
	cell_ctrl_t         ctrl;
	logic [PL_W-1:0]    pat_len;
	logic [PATTERN_MAX:0] start_chain;
	logic [PATTERN_MAX:0] match_chain;
	logic [PATTERN_MAX:0] close_chain;
	logic [PATTERN_MAX:0] closed_vec;
	logic [MODE_W-1:0]  mode_type;
	logic               type_ok;
	logic               name_ok;
	logic               ok;

	assign path.ready = !out_valid_q || result.ready;
	assign accept     = path.valid && path.ready;

	assign ctrl.load     = accept;
	assign ctrl.at_start = at_start_q;
	assign ctrl.restart  = (path.ch == CH_SLASH) && !path.last_char;
	assign ctrl.ch       = path.ch;

	assign pat_len = (pattern_length_q > LEN_W'(PATTERN_MAX)) ? PL_W'(PATTERN_MAX)
	                                                         : pattern_length_q[PL_W-1:0];

	assign start_chain[0] = 1'b1;
	assign match_chain[0] = 1'b0;
	assign close_chain[0] = 1'b0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		gntd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pchar     (pattern_words_q[i / 8][(i % 8) * CHAR_W +: CHAR_W]),
			.en        (LEN_W'(i) < pattern_length_q),
			.start_in  (start_chain[i]),
			.match_in  (match_chain[i]),
			.close_in  (close_chain[i]),
			.start_out (start_chain[i+1]),
			.match_out (match_chain[i+1]),
			.close_out (close_chain[i+1]),
			.closed    (closed_vec[i])
		);
	end

	assign closed_vec[PATTERN_MAX] = match_chain[PATTERN_MAX] || close_chain[PATTERN_MAX];

	assign mode_type = path.file_mode & MODE_TYPE_MASK;

	always_comb begin
		unique case (type_filter_q)
			TF_REG:  type_ok = (mode_type == MODE_REG);
			TF_DIR:  type_ok = (mode_type == MODE_DIR);
			TF_NONE: type_ok = 1'b1;
			TF_ANY:  type_ok = 1'b1;
			default: type_ok = 1'b1;
		endcase
	end

	assign name_ok = !name_filter_on_q || closed_vec[pat_len];
	assign ok      = (path.depth >= min_depth_q) && type_ok && name_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_filter_q    <= TF_NONE;
			min_depth_q      <= '0;
			name_filter_on_q <= 1'b0;
			pattern_length_q <= '0;
			for (int w = 0; w < NUM_WORDS; w++) begin
				pattern_words_q[w] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_TYPE_FILTER:    type_filter_q    <= type_filter_t'(cfg_wdata[1:0]);
				REG_MIN_DEPTH:      min_depth_q      <= cfg_wdata[DEPTH_W-1:0];
				REG_NAME_FILTER_ON: name_filter_on_q <= cfg_wdata[0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata[LEN_W-1:0];
				REG_PATTERN_W0:     pattern_words_q[0] <= cfg_wdata;
				REG_PATTERN_W1:     pattern_words_q[1] <= cfg_wdata;
				REG_PATTERN_W2:     pattern_words_q[2] <= cfg_wdata;
				REG_PATTERN_W3:     pattern_words_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				at_start_q <= path.last_char;
			end
			if (accept && path.last_char) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
		end else if (accept && path.last_char) begin
			matched_q <= ok;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;

`ifndef SYNTHESIS
	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && path.last_char) |=> result.valid)
		else $error("Last character beat produced no result beat.");

	a_start_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && path.last_char) |=> at_start_q)
		else $error("Path start not flagged after last character.");

	a_mid_path_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !path.last_char) |=> !at_start_q)
		else $error("Path start flagged in the middle of a path.");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !path.ready)
		else $error("Character beat taken while a result beat is stalled.");
`endif

endmodule
